FILE: rtl/core/gfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfs_pkg
// shared types, register codes, clamp helpers and the alpha table
// ----------------------------------------------------------------------------
package gfs_pkg;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_W       = 16;
    localparam int DIV_CNT_W   = $clog2(DIV_W);

    localparam logic [8:0]  FRAME_LIMIT = 9'd256;
    localparam logic [5:0]  MAX_LAYERS  = 6'd40;
    localparam logic [15:0] LFSR_POLY   = 16'hB400;

    localparam logic [8:0]  NUM_FRAMES_RST   = 9'd1;
    localparam logic [8:0]  GRAIN_LENGTH_RST = 9'd5;
    localparam logic [7:0]  GRAIN_STEP_RST   = 8'd1;
    localparam logic [8:0]  SPRAY_RST        = 9'd0;
    localparam logic [5:0]  OVERLAY_RST      = 6'd1;
    localparam logic [15:0] RANDOM_SEED_RST  = 16'd44257;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_FRAMES   = 3'd0,
        REG_GRAIN_LENGTH = 3'd1,
        REG_GRAIN_STEP   = 3'd2,
        REG_SPRAY        = 3'd3,
        REG_OVERLAY      = 3'd4,
        REG_RANDOM_SEED  = 3'd5
    } cfg_reg_e;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_BASE,
        BK_STEP,
        BK_JIT,
        BK_TSTART,
        BK_TWAIT,
        BK_EMIT,
        BK_GRAIN,
        BK_SMOD,
        BK_PMOD
    } back_state_t;

    typedef struct packed {
        logic [8:0]  num_frames;
        logic [8:0]  grain_length;
        logic [7:0]  grain_step;
        logic [8:0]  spray;
        logic [5:0]  overlay;
    } cfg_t;

    typedef struct packed {
        logic        seed_load;
        logic [15:0] seed;
        logic        gp_clear;
    } cfg_evt_t;

    typedef struct packed {
        logic [8:0] fc;
        logic [5:0] ov;
        logic [8:0] s;
        logic [7:0] alpha;
        logic [8:0] gl;
        logic [7:0] step;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [8:0]       divisor;
    } div_req_t;

    typedef struct packed {
        logic       done;
        logic [8:0] rem;
    } div_rsp_t;

    localparam logic [7:0] ALPHA_TABLE [0:40] = '{
        8'd0,   8'd255, 8'd127, 8'd85,  8'd63,  8'd51,  8'd42,  8'd36,  8'd31,
        8'd28,  8'd25,  8'd23,  8'd21,  8'd19,  8'd18,  8'd17,  8'd15,  8'd15,
        8'd14,  8'd13,  8'd12,  8'd12,  8'd11,  8'd11,  8'd10,  8'd10,  8'd9,
        8'd9,   8'd9,   8'd8,   8'd8,   8'd8,   8'd7,   8'd7,   8'd7,   8'd7,
        8'd7,   8'd6,   8'd6,   8'd6,   8'd6
    };

    function automatic logic [8:0] eff_frames(input logic [8:0] fc);
        logic [8:0] r;
        r = fc;
        if (fc == 9'd0)
            r = 9'd1;
        else if (fc > FRAME_LIMIT)
            r = FRAME_LIMIT;
        return r;
    endfunction

    function automatic logic [5:0] eff_overlay(input logic [5:0] ov);
        logic [5:0] r;
        r = ov;
        if (ov == 6'd0)
            r = 6'd1;
        else if (ov > MAX_LAYERS)
            r = MAX_LAYERS;
        return r;
    endfunction

endpackage

FILE: rtl/core/gfs_tick_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfs_tick_if
// tick channel, one beat per output frame period
// ----------------------------------------------------------------------------
interface gfs_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

FILE: rtl/core/gfs_layer_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfs_layer_if
// layer channel, one beat per blended layer
// ----------------------------------------------------------------------------
interface gfs_layer_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_index;
    logic [5:0] layer;
    logic [7:0] alpha;
    logic       last;

    modport source (output valid, output frame_index, output layer, output alpha,
                    output last, input ready);
    modport sink   (input valid, input frame_index, input layer, input alpha,
                    input last, output ready);
endinterface

FILE: rtl/core/granular_frame_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// granular_frame_scheduler_unit
// granular frame scheduler: one tick beat in, one layer beat per overlay layer
// out
// ----------------------------------------------------------------------------
// Each accepted tick with tick = 1 yields overlay layer beats, each with the
// source frame (start + grain_pos + layer + jitter) mod the frame count, the
// blend weight 255 / overlay and a last flag on the final layer. Every modulo
// goes through one shared 16-step remainder unit: the base frame, per layer a
// jitter when spray is nonzero and the frame, and two more when the grain
// wraps. A layer also waits while the layer channel is stalled. Up to two
// ticks wait in the job queue while one is worked on, and a finished layer
// sits in the output register while the next one is computed.
// ----------------------------------------------------------------------------
module granular_frame_scheduler_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    gfs_tick_if.sink                         ticks,
    gfs_layer_if.source                      layers,
    input  logic                             cfg_wr_en,
    input  logic [gfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gfs_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import gfs_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    cfg_evt_t evt;
    push_t    push;
    job_t     q_head;
    logic     q_full;
    logic     q_empty;
    logic     pop;
    div_req_t div_req;
    div_rsp_t div_rsp;
    logic     gl_ok;

    assign gl_ok = (cfg_data[8:0] != 9'd0)
                && (cfg_data[8:0] <= eff_frames(cfg_reg.num_frames));

    always_comb
    begin
        cfg_next      = cfg_reg;
        evt.seed_load = 1'b0;
        evt.seed      = (cfg_data == 16'd0) ? 16'd1 : cfg_data;
        evt.gp_clear  = 1'b0;
        if (cfg_wr_en)
        begin
            case (cfg_reg_e'(cfg_index))
                REG_NUM_FRAMES:
                    cfg_next.num_frames = cfg_data[8:0];
                REG_GRAIN_LENGTH:
                    if (gl_ok)
                    begin
                        cfg_next.grain_length = cfg_data[8:0];
                        evt.gp_clear          = 1'b1;
                    end
                REG_GRAIN_STEP:
                    cfg_next.grain_step = cfg_data[7:0];
                REG_SPRAY:
                    cfg_next.spray = cfg_data[8:0];
                REG_OVERLAY:
                    cfg_next.overlay = cfg_data[5:0];
                REG_RANDOM_SEED:
                    evt.seed_load = 1'b1;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_frames   <= NUM_FRAMES_RST;
            cfg_reg.grain_length <= GRAIN_LENGTH_RST;
            cfg_reg.grain_step   <= GRAIN_STEP_RST;
            cfg_reg.spray        <= SPRAY_RST;
            cfg_reg.overlay      <= OVERLAY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gfs_front u_front (
        .ticks  (ticks),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .push   (push)
    );

    gfs_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .empty (q_empty),
        .head  (q_head)
    );

    gfs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    gfs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .pop     (pop),
        .evt     (evt),
        .div_req (div_req),
        .div_rsp (div_rsp),
        .layers  (layers)
    );

endmodule

FILE: rtl/core/gfs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfs_div
// shared restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module gfs_div (
    input  logic              clk,
    input  logic              rst_n,
    input  gfs_pkg::div_req_t req,
    output gfs_pkg::div_rsp_t rsp
);
    import gfs_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     dvd_reg, dvd_next;
    logic [8:0]           dvs_reg, dvs_next;
    logic [8:0]           rem_reg, rem_next;
    logic [9:0]           shifted;

    assign shifted = {rem_reg, dvd_reg[DIV_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (busy_reg)
        begin
            dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            if (shifted >= {1'b0, dvs_reg})
                rem_next = 9'(shifted - {1'b0, dvs_reg});
            else
                rem_next = shifted[8:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            rem_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

FILE: rtl/core/gfs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfs_front
// takes tick beats, drops idle ones, builds a job from the clamped settings
// ----------------------------------------------------------------------------
module gfs_front (
    gfs_tick_if.sink        ticks,
    input  gfs_pkg::cfg_t   cfg,
    input  logic            q_full,
    output gfs_pkg::push_t  push
);
    import gfs_pkg::*;

    logic [8:0] fc;
    logic [5:0] ov;

    assign fc = eff_frames(cfg.num_frames);
    assign ov = eff_overlay(cfg.overlay);

    assign ticks.ready = !q_full;

    always_comb
    begin
        push.valid     = ticks.valid && !q_full && ticks.tick;
        push.job.fc    = fc;
        push.job.ov    = ov;
        push.job.s     = (cfg.spray > fc) ? fc : cfg.spray;
        push.job.alpha = ALPHA_TABLE[ov];
        push.job.gl    = (cfg.grain_length == 9'd0) ? 9'd1 : cfg.grain_length;
        push.job.step  = cfg.grain_step;
    end

endmodule

FILE: rtl/core/gfs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfs_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module gfs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  gfs_pkg::push_t  push,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output gfs_pkg::job_t   head
);
    import gfs_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push.job;
    end

endmodule

FILE: rtl/core/gfs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfs_back
// runs one tick job: layer frames, jitter lfsr, grain advance, output register
// ----------------------------------------------------------------------------
module gfs_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  gfs_pkg::job_t      q_head,
    output logic               pop,
    input  gfs_pkg::cfg_evt_t  evt,
    output gfs_pkg::div_req_t  div_req,
    input  gfs_pkg::div_rsp_t  div_rsp,
    gfs_layer_if.source        layers
);
    import gfs_pkg::*;

    back_state_t state_reg, state_next;

    logic [15:0] lfsr_reg, lfsr_next;
    logic [7:0]  start_reg, start_next;
    logic [7:0]  gp_reg, gp_next;
    logic        out_valid_reg, out_valid_next;

    job_t        job_reg, job_next;
    logic [7:0]  base_reg, base_next;
    logic [5:0]  layer_reg, layer_next;
    logic [8:0]  q_reg, q_next;
    logic [7:0]  frame_reg, frame_next;
    logic [7:0]  a_reg, a_next;
    logic [7:0]  out_frame_reg, out_frame_next;
    logic [5:0]  out_layer_reg, out_layer_next;
    logic [7:0]  out_alpha_reg, out_alpha_next;
    logic        out_last_reg, out_last_next;

    logic [15:0] lfsr_step;
    logic        out_free;
    logic        last_layer;
    logic [8:0]  gp_inc;
    logic        grain_wrap;
    logic [8:0]  pos_sum;
    logic [10:0] t_val;
    logic [16:0] prod;
    logic [8:0]  start_sum;

    assign lfsr_step  = {1'b0, lfsr_reg[15:1]} ^ (lfsr_reg[0] ? LFSR_POLY : 16'd0);
    assign out_free   = !out_valid_reg || layers.ready;
    assign last_layer = (layer_reg == 6'(job_reg.ov - 6'd1));
    assign gp_inc     = {1'b0, gp_reg} + 9'd1;
    assign grain_wrap = (gp_inc >= job_reg.gl);
    assign pos_sum    = {1'b0, start_reg} + {1'b0, gp_reg};
    assign t_val      = 11'(base_reg) + 11'(layer_reg) + 11'({q_reg, 1'b0})
                      + 11'(job_reg.fc) - 11'(job_reg.s);
    assign prod       = 17'(job_reg.gl) * 17'(job_reg.step);
    assign start_sum  = {1'b0, a_reg} + {1'b0, div_rsp.rem[7:0]};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
                if (!q_empty)
                    state_next = BK_BASE;
            BK_BASE:
                if (div_rsp.done)
                    state_next = BK_STEP;
            BK_STEP:
                state_next = (job_reg.s != 9'd0) ? BK_JIT : BK_TSTART;
            BK_JIT:
                if (div_rsp.done)
                    state_next = BK_TSTART;
            BK_TSTART:
                state_next = BK_TWAIT;
            BK_TWAIT:
                if (div_rsp.done)
                    state_next = BK_EMIT;
            BK_EMIT:
                if (out_free)
                    state_next = last_layer ? BK_GRAIN : BK_STEP;
            BK_GRAIN:
                state_next = grain_wrap ? BK_SMOD : BK_IDLE;
            BK_SMOD:
                if (div_rsp.done)
                    state_next = BK_PMOD;
            BK_PMOD:
                if (div_rsp.done)
                    state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        lfsr_next      = lfsr_reg;
        start_next     = start_reg;
        gp_next        = gp_reg;
        out_valid_next = out_valid_reg && !layers.ready;
        job_next       = job_reg;
        base_next      = base_reg;
        layer_next     = layer_reg;
        q_next         = q_reg;
        frame_next     = frame_reg;
        a_next         = a_reg;
        out_frame_next = out_frame_reg;
        out_layer_next = out_layer_reg;
        out_alpha_next = out_alpha_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        div_req        = '0;

        case (state_reg)
            BK_IDLE:
                if (!q_empty)
                begin
                    pop              = 1'b1;
                    job_next         = q_head;
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'(pos_sum);
                    div_req.divisor  = q_head.fc;
                end
            BK_BASE:
                if (div_rsp.done)
                begin
                    base_next  = div_rsp.rem[7:0];
                    layer_next = '0;
                end
            BK_STEP:
            begin
                lfsr_next = lfsr_step;
                q_next    = '0;
                if (job_reg.s != 9'd0)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = lfsr_step;
                    div_req.divisor  = job_reg.s;
                end
            end
            BK_JIT:
                if (div_rsp.done)
                    q_next = div_rsp.rem;
            BK_TSTART:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(t_val);
                div_req.divisor  = job_reg.fc;
            end
            BK_TWAIT:
                if (div_rsp.done)
                    frame_next = div_rsp.rem[7:0];
            BK_EMIT:
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_frame_next = frame_reg;
                    out_layer_next = layer_reg;
                    out_alpha_next = job_reg.alpha;
                    out_last_next  = last_layer;
                    if (!last_layer)
                        layer_next = layer_reg + 6'd1;
                end
            BK_GRAIN:
                if (grain_wrap)
                begin
                    gp_next          = '0;
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'(start_reg);
                    div_req.divisor  = job_reg.fc;
                end
                else
                begin
                    gp_next = gp_inc[7:0];
                end
            BK_SMOD:
                if (div_rsp.done)
                begin
                    a_next           = div_rsp.rem[7:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = prod[DIV_W-1:0];
                    div_req.divisor  = job_reg.fc;
                end
            BK_PMOD:
                if (div_rsp.done)
                begin
                    if (start_sum >= job_reg.fc)
                        start_next = 8'(start_sum - job_reg.fc);
                    else
                        start_next = start_sum[7:0];
                end
            default:
            begin
            end
        endcase

        if (evt.seed_load)
            lfsr_next = evt.seed;
        if (evt.gp_clear)
            gp_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            lfsr_reg      <= RANDOM_SEED_RST;
            start_reg     <= '0;
            gp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lfsr_reg      <= lfsr_next;
            start_reg     <= start_next;
            gp_reg        <= gp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg       <= job_next;
        base_reg      <= base_next;
        layer_reg     <= layer_next;
        q_reg         <= q_next;
        frame_reg     <= frame_next;
        a_reg         <= a_next;
        out_frame_reg <= out_frame_next;
        out_layer_reg <= out_layer_next;
        out_alpha_reg <= out_alpha_next;
        out_last_reg  <= out_last_next;
    end

    assign layers.valid       = out_valid_reg;
    assign layers.frame_index = out_frame_reg;
    assign layers.layer       = out_layer_reg;
    assign layers.alpha       = out_alpha_reg;
    assign layers.last        = out_last_reg;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for granular_frame_scheduler_unit
// ----------------------------------------------------------------------------
// Drives tick beats and register writes, keeps its own copy of the scheduler
// state (start frame, grain position, jitter lfsr, registers), and checks
// every layer beat against the oldest predicted one. Directed cases cover
// reset values, grain wrap, rejected grain length writes, clamped registers,
// a stale start frame after the frame count is lowered, seed reload and unused
// register indexes. Random phases then change registers and send ticks
// with random idling on both channels. The last phase runs without idling.
// ----------------------------------------------------------------------------
module testbench;
    import gfs_pkg::*;

    localparam int          CLK_PERIOD     = 20;
    localparam int          SETTLE_CYCLES  = 2000;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          RANDOM_TICKS   = 180;
    localparam int          STEADY_TICKS   = 30;
    localparam logic [15:0] JITTER_POLY    = 16'hB400;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

    typedef struct {
        logic [7:0] frame_index;
        logic [5:0] layer;
        logic [7:0] alpha;
        logic       last;
    } layer_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gfs_tick_if  tick_bus ();
    gfs_layer_if layer_bus ();

    granular_frame_scheduler_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .ticks     (tick_bus),
        .layers    (layer_bus),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // scheduler state as the bench sees it
    logic [8:0]  cfg_frames;
    logic [8:0]  cfg_grain_len;
    logic [7:0]  cfg_step;
    logic [8:0]  cfg_spray;
    logic [5:0]  cfg_layers;
    logic [15:0] cfg_seed;
    logic [7:0]  start_pos;
    logic [7:0]  grain_off;
    logic [15:0] jitter_state;

    layer_beat_t pending_layers [$];
    int          error_count;
    bit          idle_on;

    function automatic int unsigned frames_in_use();
        if (cfg_frames == 9'd0)
            return 1;
        if (cfg_frames > 9'd256)
            return 256;
        return cfg_frames;
    endfunction

    function automatic int unsigned layers_in_use();
        if (cfg_layers == 6'd0)
            return 1;
        if (cfg_layers > 6'd40)
            return 40;
        return cfg_layers;
    endfunction

    task automatic reload_jitter();
        jitter_state = (cfg_seed == 16'd0) ? 16'd1 : cfg_seed;
    endtask

    task automatic reset_schedule();
        cfg_frames    = 9'd1;
        cfg_grain_len = 9'd5;
        cfg_step      = 8'd1;
        cfg_spray     = 9'd0;
        cfg_layers    = 6'd1;
        cfg_seed      = 16'd44257;
        start_pos     = 8'd0;
        grain_off     = 8'd0;
        reload_jitter();
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        case (idx)
            REG_NUM_FRAMES:   cfg_frames = data[8:0];
            REG_GRAIN_LENGTH:
            begin
                if (data[8:0] != 9'd0 && data[8:0] <= frames_in_use())
                begin
                    cfg_grain_len = data[8:0];
                    grain_off     = 8'd0;
                end
            end
            REG_GRAIN_STEP:   cfg_step = data[7:0];
            REG_SPRAY:        cfg_spray = data[8:0];
            REG_OVERLAY:      cfg_layers = data[5:0];
            REG_RANDOM_SEED:
            begin
                cfg_seed = data;
                reload_jitter();
            end
            default: ;
        endcase
    endtask

    task automatic predict_layers(input logic tick_val);
        int unsigned fc;
        int unsigned ov;
        int unsigned s;
        int unsigned base;
        int unsigned i;
        int unsigned nxt;
        int          jit;
        int          sum;
        layer_beat_t beat;
        if (!tick_val)
            return;
        fc   = frames_in_use();
        ov   = layers_in_use();
        s    = (cfg_spray > fc) ? fc : cfg_spray;
        base = (start_pos + grain_off) % fc;
        for (i = 0; i < ov; i++)
        begin
            jitter_state = jitter_state[0] ? ((jitter_state >> 1) ^ JITTER_POLY)
                                           : (jitter_state >> 1);
            jit = 0;
            if (s > 0)
                jit = int'((jitter_state % s) * 2) - int'(s);
            sum = int'(base) + int'(i) + jit + int'(fc);
            beat.frame_index = 8'(sum % int'(fc));
            beat.layer       = 6'(i);
            beat.alpha       = 8'(255 / ov);
            beat.last        = (i + 1 == ov);
            pending_layers.push_back(beat);
        end
        nxt = (grain_off + 1) & 9'h1FF;
        if (nxt >= cfg_grain_len)
        begin
            nxt       = 0;
            start_pos = 8'(((start_pos % fc) + (cfg_grain_len * cfg_step) % fc) % fc);
        end
        grain_off = 8'(nxt);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_reg(idx, data);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_tick(input logic tick_val);
        int gap;
        gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            tick_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick_bus.valid <= 1'b1;
        tick_bus.tick  <= tick_val;
        do
            @(posedge clk);
        while (!tick_bus.ready);
        predict_layers(tick_val);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        tick_bus.valid <= 1'b0;
        while (pending_layers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_tick(1'b1);
    endtask

    task automatic test_reset_state();
        send_ticks(2);
        send_tick(1'b0);
        wait_drained();
    endtask

    task automatic test_grain_wrap();
        write_reg(REG_NUM_FRAMES, 16'd7);
        write_reg(REG_GRAIN_LENGTH, 16'd3);
        write_reg(REG_GRAIN_STEP, 16'd2);
        write_reg(REG_SPRAY, 16'd0);
        write_reg(REG_OVERLAY, 16'd2);
        send_ticks(7);
        wait_drained();
        // rejected lengths keep the grain position
        write_reg(REG_GRAIN_LENGTH, 16'd0);
        write_reg(REG_GRAIN_LENGTH, 16'd8);
        send_ticks(1);
        wait_drained();
        write_reg(REG_GRAIN_LENGTH, 16'hFE04);
        send_ticks(1);
        wait_drained();
    endtask

    task automatic test_field_extremes();
        write_reg(REG_NUM_FRAMES, 16'd256);
        write_reg(REG_GRAIN_LENGTH, 16'd256);
        write_reg(REG_GRAIN_STEP, 16'd255);
        write_reg(REG_SPRAY, 16'd256);
        write_reg(REG_OVERLAY, 16'd40);
        write_reg(REG_RANDOM_SEED, 16'd0);
        send_ticks(1);
        wait_drained();
        write_reg(REG_NUM_FRAMES, 16'hFFFF);
        write_reg(REG_SPRAY, 16'h01FF);
        write_reg(REG_OVERLAY, 16'h003F);
        write_reg(REG_RANDOM_SEED, 16'hFFFF);
        send_ticks(1);
        wait_drained();
        write_reg(REG_NUM_FRAMES, 16'd0);
        write_reg(REG_OVERLAY, 16'hFFC0);
        send_ticks(1);
        wait_drained();
    endtask

    task automatic test_stale_start();
        write_reg(REG_NUM_FRAMES, 16'd256);
        write_reg(REG_GRAIN_LENGTH, 16'd1);
        write_reg(REG_GRAIN_STEP, 16'd255);
        write_reg(REG_SPRAY, 16'd0);
        write_reg(REG_OVERLAY, 16'd3);
        send_ticks(2);
        wait_drained();
        write_reg(REG_NUM_FRAMES, 16'd10);
        write_reg(REG_SPRAY, 16'd3);
        send_ticks(2);
        wait_drained();
    endtask

    task automatic test_unused_regs();
        write_reg(REG_UNUSED_6, 16'hFFFF);
        write_reg(REG_UNUSED_7, 16'hFFFF);
        send_ticks(1);
        wait_drained();
        write_reg(REG_RANDOM_SEED, 16'h1234);
        send_ticks(1);
        wait_drained();
    endtask

    task automatic randomize_settings();
        logic [8:0]  fc;
        logic [8:0]  gl;
        logic [8:0]  sp;
        logic [5:0]  ov;
        logic [15:0] seed;
        int unsigned lim;
        case ($urandom_range(0, 5))
            0:       fc = 9'($urandom_range(1, 8));
            1:       fc = $urandom_range(0, 1) ? 9'd0 : 9'($urandom_range(257, 511));
            2:       fc = 9'd256;
            default: fc = 9'($urandom_range(1, 256));
        endcase
        write_reg(REG_NUM_FRAMES, {7'($urandom), fc});
        lim = frames_in_use();
        if ($urandom_range(0, 4) != 0)
        begin
            if ($urandom_range(0, 7) == 0)
                gl = $urandom_range(0, 1) ? 9'd0 : 9'($urandom_range(0, 511));
            else if ($urandom_range(0, 9) == 0)
                gl = 9'(lim);
            else
                gl = 9'($urandom_range(1, (lim < 12) ? lim : 12));
            write_reg(REG_GRAIN_LENGTH, {7'($urandom), gl});
        end
        write_reg(REG_GRAIN_STEP, 16'($urandom));
        case ($urandom_range(0, 3))
            0:       sp = 9'd0;
            1:       sp = 9'($urandom_range(1, 4));
            2:       sp = 9'($urandom_range(0, 511));
            default: sp = 9'(lim);
        endcase
        write_reg(REG_SPRAY, {7'($urandom), sp});
        if ($urandom_range(0, 9) == 0)
            ov = 6'($urandom_range(0, 63));
        else
            ov = 6'($urandom_range(1, 6));
        write_reg(REG_OVERLAY, {10'($urandom), ov});
        if ($urandom_range(0, 2) == 0)
        begin
            seed = ($urandom_range(0, 20) == 0) ? 16'd0 : 16'($urandom);
            write_reg(REG_RANDOM_SEED, seed);
        end
        if ($urandom_range(0, 7) == 0)
            write_reg($urandom_range(0, 1) ? REG_UNUSED_6 : REG_UNUSED_7, 16'($urandom));
    endtask

    task automatic test_random_schedule();
        int sent;
        int burst;
        int n;
        sent = 0;
        while (sent < RANDOM_TICKS)
        begin
            wait_drained();
            idle_on = ($urandom_range(0, 3) != 0);
            randomize_settings();
            burst = $urandom_range(6, 24);
            for (n = 0; n < burst; n++)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_tick(1'b0);
                else
                begin
                    send_tick(1'b1);
                    sent++;
                end
            end
        end
        wait_drained();
    endtask

    task automatic test_steady_flow();
        idle_on = 1'b0;
        write_reg(REG_NUM_FRAMES, 16'd64);
        write_reg(REG_GRAIN_LENGTH, 16'd4);
        write_reg(REG_GRAIN_STEP, 16'd3);
        write_reg(REG_SPRAY, 16'd5);
        write_reg(REG_OVERLAY, 16'd4);
        send_ticks(STEADY_TICKS);
        wait_drained();
    endtask

    // layer beat checker
    always @(posedge clk)
    begin : layer_check
        layer_beat_t want;
        if (rst_n && layer_bus.valid && layer_bus.ready)
        begin
            if (pending_layers.size() == 0)
            begin
                $display("%0t: unexpected layer beat: expected none, got frame %0d layer %0d",
                         $time, layer_bus.frame_index, layer_bus.layer);
                error_count++;
            end
            else
            begin
                want = pending_layers.pop_front();
                if (layer_bus.frame_index !== want.frame_index)
                begin
                    $display("%0t: frame_index mismatch: expected %0d, got %0d",
                             $time, want.frame_index, layer_bus.frame_index);
                    error_count++;
                end
                if (layer_bus.layer !== want.layer)
                begin
                    $display("%0t: layer mismatch: expected %0d, got %0d",
                             $time, want.layer, layer_bus.layer);
                    error_count++;
                end
                if (layer_bus.alpha !== want.alpha)
                begin
                    $display("%0t: alpha mismatch: expected %0d, got %0d",
                             $time, want.alpha, layer_bus.alpha);
                    error_count++;
                end
                if (layer_bus.last !== want.last)
                begin
                    $display("%0t: last mismatch: expected %0d, got %0d",
                             $time, want.last, layer_bus.last);
                    error_count++;
                end
            end
        end
    end

    // random backpressure on the layer channel
    initial
    begin : layer_stall
        int stall_left;
        stall_left      = 0;
        layer_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 19);
            if (stall_left > 0)
            begin
                layer_bus.ready <= 1'b0;
                stall_left--;
            end
            else
                layer_bus.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((tick_bus.valid && tick_bus.ready) || (layer_bus.valid && layer_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        tick_bus.valid  = 1'b0;
        tick_bus.tick   = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        rst_n           = 1'b0;
        idle_on         = 1'b1;
        error_count     = 0;
        reset_schedule();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_grain_wrap();
        test_field_extremes();
        test_stale_start();
        test_unused_regs();
        test_random_schedule();
        test_steady_flow();

        if (error_count == 0 && pending_layers.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
